// File: hw/rtl/pdb_pkg.sv
package pdb_pkg;

    localparam int COORD_W    = 16;
    localparam int DSQ_W      = 33;
    localparam int DRES_W     = 17;
    localparam int BEAR_W     = 16;
    localparam int ANG_FRAC   = 13;
    localparam int ZQ         = 30;
    localparam int XY_W       = 64;
    localparam int Z_W        = 34;
    localparam int ROOT_W     = 34;
    localparam int SQRT_STEPS = 17;
    localparam int PRESHIFT   = XY_W - 4 - COORD_W;
    localparam int RND_SHIFT  = ZQ - ANG_FRAC;

    localparam logic signed [Z_W-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

    typedef struct packed {
        logic dx_zero;
        logic dy_zero;
        logic dx_neg;
        logic dy_neg;
    } t_flags;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic [DSQ_W-1:0]       rem;
        logic [ROOT_W-1:0]      root;
        logic [DSQ_W-1:0]       sq;
        t_flags                 flags;
    } t_work;

    function automatic logic signed [Z_W-1:0] pdb_atan(input int k);
        case (k)
            0:       return 34'sd843314857;
            1:       return 34'sd497837829;
            2:       return 34'sd263043837;
            3:       return 34'sd133525159;
            4:       return 34'sd67021687;
            5:       return 34'sd33543516;
            6:       return 34'sd16775851;
            7:       return 34'sd8388437;
            8:       return 34'sd4194283;
            9:       return 34'sd2097149;
            10:      return 34'sd1048576;
            11:      return 34'sd524288;
            12:      return 34'sd262144;
            13:      return 34'sd131072;
            14:      return 34'sd65536;
            15:      return 34'sd32768;
            16:      return 34'sd16384;
            17:      return 34'sd8192;
            18:      return 34'sd4096;
            19:      return 34'sd2048;
            20:      return 34'sd1024;
            21:      return 34'sd512;
            22:      return 34'sd256;
            23:      return 34'sd128;
            24:      return 34'sd64;
            25:      return 34'sd32;
            26:      return 34'sd16;
            27:      return 34'sd8;
            28:      return 34'sd4;
            29:      return 34'sd2;
            default: return 34'sd1;
        endcase
    endfunction

endpackage

// File: hw/rtl/pdb_in_if.sv
interface pdb_in_if;
    import pdb_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] ref_x;
    logic signed [COORD_W-1:0] ref_y;
    logic signed [COORD_W-1:0] other_x;
    logic signed [COORD_W-1:0] other_y;

    modport source (output valid, output ref_x, output ref_y, output other_x,
                    output other_y, input ready);
    modport sink (input valid, input ref_x, input ref_y, input other_x,
                  input other_y, output ready);
endinterface

// File: hw/rtl/pdb_out_if.sv
interface pdb_out_if;
    import pdb_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [DSQ_W-1:0]         dist_squared;
    logic [DRES_W-1:0]        dist_res;
    logic signed [BEAR_W-1:0] bearing;
    logic                     same_point;

    modport source (output valid, output dist_squared, output dist_res, output bearing,
                    output same_point, input ready);
    modport sink (input valid, input dist_squared, input dist_res, input bearing,
                  input same_point, output ready);
endinterface

// File: hw/rtl/pdb_front.sv
module pdb_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [pdb_pkg::COORD_W-1:0] i_ref_x,
    input  logic signed [pdb_pkg::COORD_W-1:0] i_ref_y,
    input  logic signed [pdb_pkg::COORD_W-1:0] i_other_x,
    input  logic signed [pdb_pkg::COORD_W-1:0] i_other_y,
    output logic                               o_valid,
    input  logic                               i_ready,
    output pdb_pkg::t_work                     o_work
);
    import pdb_pkg::*;

    logic [2:0]                 r_valid;
    logic [2:0]                 rdy;
    logic signed [COORD_W:0]    r_dx;
    logic signed [COORD_W:0]    r_dy;
    logic [COORD_W-1:0]         r_ux;
    logic [COORD_W-1:0]         r_uy;
    logic [2*COORD_W-1:0]       r_sqx;
    logic [2*COORD_W-1:0]       r_sqy;
    t_flags                     r_flags;
    t_work                      r_work;
    logic [COORD_W:0]           abs_x;
    logic [COORD_W:0]           abs_y;
    logic [DSQ_W-1:0]           sq_sum;

    assign rdy[2]  = !r_valid[2] || i_ready;
    assign rdy[1]  = !r_valid[1] || rdy[2];
    assign rdy[0]  = !r_valid[0] || rdy[1];
    assign o_ready = rdy[0];

    assign abs_x  = r_dx[COORD_W] ? (COORD_W+1)'(-r_dx) : (COORD_W+1)'(r_dx);
    assign abs_y  = r_dy[COORD_W] ? (COORD_W+1)'(-r_dy) : (COORD_W+1)'(r_dy);
    assign sq_sum = DSQ_W'(r_sqx) + DSQ_W'(r_sqy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (rdy[0]) begin
                r_valid[0] <= i_valid;
            end
            if (rdy[1]) begin
                r_valid[1] <= r_valid[0];
            end
            if (rdy[2]) begin
                r_valid[2] <= r_valid[1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && rdy[0]) begin
            r_dx <= (COORD_W+1)'(i_other_x) - (COORD_W+1)'(i_ref_x);
            r_dy <= (COORD_W+1)'(i_other_y) - (COORD_W+1)'(i_ref_y);
        end
        if (r_valid[0] && rdy[1]) begin
            r_ux            <= abs_x[COORD_W-1:0];
            r_uy            <= abs_y[COORD_W-1:0];
            r_sqx           <= (2*COORD_W)'(abs_x[COORD_W-1:0])
                               * (2*COORD_W)'(abs_x[COORD_W-1:0]);
            r_sqy           <= (2*COORD_W)'(abs_y[COORD_W-1:0])
                               * (2*COORD_W)'(abs_y[COORD_W-1:0]);
            r_flags.dx_zero <= (r_dx == '0);
            r_flags.dy_zero <= (r_dy == '0);
            r_flags.dx_neg  <= r_dx[COORD_W];
            r_flags.dy_neg  <= r_dy[COORD_W];
        end
        if (r_valid[1] && rdy[2]) begin
            r_work.x     <= XY_W'(r_ux) << PRESHIFT;
            r_work.y     <= XY_W'(r_uy) << PRESHIFT;
            r_work.z     <= '0;
            r_work.rem   <= sq_sum;
            r_work.root  <= '0;
            r_work.sq    <= sq_sum;
            r_work.flags <= r_flags;
        end
    end

    assign o_valid = r_valid[2];
    assign o_work  = r_work;

endmodule

// File: hw/rtl/pdb_cell.sv
module pdb_cell #(
    parameter int STEP    = 0,
    parameter bit DO_ROT  = 1'b1,
    parameter bit DO_SQRT = 1'b1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  pdb_pkg::t_work i_work,
    output logic           o_valid,
    input  logic           i_ready,
    output pdb_pkg::t_work o_work
);
    import pdb_pkg::*;

    localparam int                    SQ_SHIFT = DO_SQRT ? 2 * (SQRT_STEPS - 1 - STEP) : 0;
    localparam logic [ROOT_W-1:0]     SQ_BIT   = ROOT_W'(1) << SQ_SHIFT;
    localparam logic signed [Z_W-1:0] ATAN_K   = pdb_atan(STEP);

    logic                   r_valid;
    t_work                  r_work;
    t_work                  n_work;
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    logic [ROOT_W:0]        trial;
    logic                   take;

    assign o_ready = !r_valid || i_ready;
    assign take    = i_valid && o_ready;

    always_comb begin
        n_work = i_work;
        xs     = $signed(i_work.x) >>> STEP;
        ys     = $signed(i_work.y) >>> STEP;
        trial  = {1'b0, i_work.root} + {1'b0, SQ_BIT};
        if (DO_ROT) begin
            if (!i_work.y[XY_W-1]) begin
                n_work.x = i_work.x + ys;
                n_work.y = i_work.y - xs;
                n_work.z = i_work.z + ATAN_K;
            end else begin
                n_work.x = i_work.x - ys;
                n_work.y = i_work.y + xs;
                n_work.z = i_work.z - ATAN_K;
            end
        end
        if (DO_SQRT) begin
            if ({2'b0, i_work.rem} >= trial) begin
                n_work.rem  = i_work.rem - DSQ_W'(trial);
                n_work.root = (i_work.root >> 1) + SQ_BIT;
            end else begin
                n_work.root = i_work.root >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_work <= n_work;
        end
    end

    assign o_valid = r_valid;
    assign o_work  = r_work;

endmodule

// File: hw/rtl/pdb_back.sv
module pdb_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  pdb_pkg::t_work                    i_work,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [pdb_pkg::DSQ_W-1:0]         o_dist_squared,
    output logic [pdb_pkg::DRES_W-1:0]        o_dist_res,
    output logic signed [pdb_pkg::BEAR_W-1:0] o_bearing,
    output logic                              o_same_point
);
    import pdb_pkg::*;

    localparam int MAG_W = Z_W + 1 - RND_SHIFT;

    logic [2:0]              rdy;
    logic [2:0]              r_valid;
    logic signed [Z_W-1:0]   r_m;
    logic                    r_neg0;
    logic                    r_neg1;
    logic [MAG_W-1:0]        r_mag;
    logic [DSQ_W-1:0]        r_sq0;
    logic [DSQ_W-1:0]        r_sq1;
    logic [DSQ_W-1:0]        r_sq2;
    logic [DRES_W-1:0]       r_root0;
    logic [DRES_W-1:0]       r_root1;
    logic [DRES_W-1:0]       r_root2;
    logic [2:0]              r_same;
    logic signed [BEAR_W-1:0] r_bearing;
    logic signed [Z_W-1:0]   m_sel;
    logic                    neg_sel;
    logic [Z_W-1:0]          abs_m;
    logic [Z_W:0]            rnd_sum;
    logic [MAG_W-1:0]        sgn_mag;

    assign rdy[2]  = !r_valid[2] || i_ready;
    assign rdy[1]  = !r_valid[1] || rdy[2];
    assign rdy[0]  = !r_valid[0] || rdy[1];
    assign o_ready = rdy[0];

    always_comb begin
        if (i_work.flags.dx_zero) begin
            m_sel   = i_work.flags.dy_zero ? '0 : HALF_PI_Q30;
            neg_sel = i_work.flags.dy_neg;
        end else if (i_work.flags.dy_zero) begin
            m_sel   = i_work.flags.dx_neg ? PI_Q30 : '0;
            neg_sel = 1'b0;
        end else begin
            m_sel   = i_work.flags.dx_neg ? PI_Q30 - i_work.z : i_work.z;
            neg_sel = i_work.flags.dy_neg;
        end
    end

    assign abs_m   = r_m[Z_W-1] ? Z_W'(-r_m) : Z_W'(r_m);
    assign rnd_sum = {1'b0, abs_m} + ((Z_W+1)'(1) << (RND_SHIFT - 1));
    assign sgn_mag = r_neg1 ? -r_mag : r_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (rdy[0]) begin
                r_valid[0] <= i_valid;
            end
            if (rdy[1]) begin
                r_valid[1] <= r_valid[0];
            end
            if (rdy[2]) begin
                r_valid[2] <= r_valid[1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && rdy[0]) begin
            r_m       <= m_sel;
            r_neg0    <= neg_sel;
            r_sq0     <= i_work.sq;
            r_root0   <= i_work.root[DRES_W-1:0];
            r_same[0] <= i_work.flags.dx_zero && i_work.flags.dy_zero;
        end
        if (r_valid[0] && rdy[1]) begin
            r_mag     <= rnd_sum[Z_W:RND_SHIFT];
            r_neg1    <= r_neg0 ^ r_m[Z_W-1];
            r_sq1     <= r_sq0;
            r_root1   <= r_root0;
            r_same[1] <= r_same[0];
        end
        if (r_valid[1] && rdy[2]) begin
            r_bearing <= sgn_mag[BEAR_W-1:0];
            r_sq2     <= r_sq1;
            r_root2   <= r_root1;
            r_same[2] <= r_same[1];
        end
    end

    assign o_valid        = r_valid[2];
    assign o_dist_squared = r_sq2;
    assign o_dist_res     = r_root2;
    assign o_bearing      = r_bearing;
    assign o_same_point   = r_same[2];

endmodule

// File: hw/rtl/point_distance_and_bearing_unit.sv
// A point pair passes through the front end stages, the CORDIC and square root cells and
// the back end stages, all registered. Throughput: one beat per cycle unless the output
// stalls; every pipeline stage, including each CORDIC and square root cell, holds one item
// and has its own valid bit, so bubbles close up under stalls. Reset clears all stage valid
// bits at once; the block accepts a beat in the first cycle after.
module point_distance_and_bearing_unit #(
    parameter int CORDIC_STEPS = 16
) (
    input logic       i_clk,
    input logic       i_rst_n,
    pdb_in_if.sink    i_pt,
    pdb_out_if.source o_res
);
    import pdb_pkg::*;

    localparam int N_CELLS = (CORDIC_STEPS > SQRT_STEPS) ? CORDIC_STEPS : SQRT_STEPS;

    logic [N_CELLS:0] cv;
    logic [N_CELLS:0] cr;
    t_work            cw [N_CELLS+1];

    pdb_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_pt.valid),
        .o_ready   (i_pt.ready),
        .i_ref_x   (i_pt.ref_x),
        .i_ref_y   (i_pt.ref_y),
        .i_other_x (i_pt.other_x),
        .i_other_y (i_pt.other_y),
        .o_valid   (cv[0]),
        .i_ready   (cr[0]),
        .o_work    (cw[0])
    );

    for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
        pdb_cell #(
            .STEP    (g),
            .DO_ROT  (g < CORDIC_STEPS),
            .DO_SQRT (g < SQRT_STEPS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (cv[g]),
            .o_ready (cr[g]),
            .i_work  (cw[g]),
            .o_valid (cv[g+1]),
            .i_ready (cr[g+1]),
            .o_work  (cw[g+1])
        );
    end

    pdb_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (cv[N_CELLS]),
        .o_ready        (cr[N_CELLS]),
        .i_work         (cw[N_CELLS]),
        .o_valid        (o_res.valid),
        .i_ready        (o_res.ready),
        .o_dist_squared (o_res.dist_squared),
        .o_dist_res     (o_res.dist_res),
        .o_bearing      (o_res.bearing),
        .o_same_point   (o_res.same_point)
    );

endmodule

// File: hw/rtl/pdb_checker.sv
module pdb_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic [pdb_pkg::DSQ_W-1:0]         i_dist_squared,
    input logic [pdb_pkg::DRES_W-1:0]        i_dist_res,
    input logic signed [pdb_pkg::BEAR_W-1:0] i_bearing,
    input logic                              i_same_point
);
    import pdb_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_dist_squared)
            && $stable(i_dist_res) && $stable(i_bearing) && $stable(i_same_point))
        else $error("Result beat changed while stalled.");

    a_same_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_same_point == (i_dist_squared == '0)))
        else $error("Same point flag disagrees with the squared distance.");

    a_same_bearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_same_point |-> i_bearing == '0 && i_dist_res == '0)
        else $error("Coincident points gave a nonzero bearing or distance.");

    a_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (36'(i_dist_res) * 36'(i_dist_res) <= 36'(i_dist_squared))
            && (36'(i_dist_squared) < (36'(i_dist_res) + 36'd1) * (36'(i_dist_res) + 36'd1)))
        else $error("Distance is not the floor of the square root.");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_bearing >= -16'sd25736 && i_bearing <= 16'sd25736)
        else $error("Bearing is outside plus or minus pi.");

endmodule

bind point_distance_and_bearing_unit pdb_checker u_pdb_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_dist_squared (o_res.dist_squared),
    .i_dist_res     (o_res.dist_res),
    .i_bearing      (o_res.bearing),
    .i_same_point   (o_res.same_point)
);

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import pdb_pkg::*;

    localparam int     CORDIC_STEPS     = 16;
    localparam int     RANDOM_PAIRS     = 1250;
    localparam int     LONG_STALL       = 200;
    localparam int     PIPE_DEPTH       = 22;
    localparam int     ROUND_BITS       = ZQ - ANG_FRAC;
    localparam longint HALF_TURN_Q30    = 64'sd3373259426;
    localparam longint QUARTER_TURN_Q30 = 64'sd1686629713;

    typedef struct packed {
        logic signed [COORD_W-1:0] ref_x;
        logic signed [COORD_W-1:0] ref_y;
        logic signed [COORD_W-1:0] other_x;
        logic signed [COORD_W-1:0] other_y;
    } pair_t;

    typedef struct packed {
        logic [DSQ_W-1:0]         dist_squared;
        logic [DRES_W-1:0]        dist_res;
        logic signed [BEAR_W-1:0] bearing;
        logic                     same_point;
    } fix_t;

    class bearing_ledger;
        fix_t   pending_fixes[$];
        int     errors;
        int     pairs_seen;
        int     fixes_checked;
        longint atan_q30[CORDIC_STEPS];

        function new();
            atan_q30 = '{843314857, 497837829, 263043837, 133525159,
                         67021687, 33543516, 16775851, 8388437,
                         4194283, 2097149, 1048576, 524288,
                         262144, 131072, 65536, 32768};
            errors = 0;
            pairs_seen = 0;
            fixes_checked = 0;
        endfunction

        function fix_t predict_fix(pair_t p);
            longint dx, dy, ax, ay, cx, cy, cz, sx, sy, mag;
            longint unsigned sq, rem, root, bit_w;
            logic neg;
            fix_t f;
            dx = longint'($signed(p.other_x)) - longint'($signed(p.ref_x));
            dy = longint'($signed(p.other_y)) - longint'($signed(p.ref_y));
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            sq = ax * ax + ay * ay;

            rem = sq;
            root = 0;
            bit_w = 64'd1 << 62;
            while (bit_w > rem) bit_w = bit_w >> 2;
            while (bit_w != 0) begin
                if (rem >= root + bit_w) begin
                    rem = rem - (root + bit_w);
                    root = (root >> 1) + bit_w;
                end else begin
                    root = root >> 1;
                end
                bit_w = bit_w >> 2;
            end

            neg = 1'b0;
            if (dx == 0) begin
                mag = (dy == 0) ? 0 : QUARTER_TURN_Q30;
                neg = (dy < 0);
            end else if (dy == 0) begin
                mag = (dx > 0) ? 0 : HALF_TURN_Q30;
            end else begin
                // Vectoring rotations on the first-quadrant magnitudes.
                cx = ax <<< (60 - COORD_W);
                cy = ay <<< (60 - COORD_W);
                cz = 0;
                for (int k = 0; k < CORDIC_STEPS; k++) begin
                    sx = cx >>> k;
                    sy = cy >>> k;
                    if (cy >= 0) begin
                        cx = cx + sy;
                        cy = cy - sx;
                        cz = cz + atan_q30[k];
                    end else begin
                        cx = cx - sy;
                        cy = cy + sx;
                        cz = cz - atan_q30[k];
                    end
                end
                mag = (dx > 0) ? cz : HALF_TURN_Q30 - cz;
                neg = (dy < 0);
            end
            if (mag < 0) begin
                mag = -mag;
                neg = !neg;
            end
            mag = (mag + (longint'(1) <<< (ROUND_BITS - 1))) >>> ROUND_BITS;
            if (neg) mag = -mag;

            f.dist_squared = sq[DSQ_W-1:0];
            f.dist_res     = root[DRES_W-1:0];
            f.bearing      = mag[BEAR_W-1:0];
            f.same_point   = (dx == 0 && dy == 0);
            return f;
        endfunction

        function void note_pair(logic signed [COORD_W-1:0] rx, logic signed [COORD_W-1:0] ry,
                                logic signed [COORD_W-1:0] ox, logic signed [COORD_W-1:0] oy);
            pair_t p;
            p.ref_x = rx;
            p.ref_y = ry;
            p.other_x = ox;
            p.other_y = oy;
            pending_fixes.push_back(predict_fix(p));
            pairs_seen++;
        endfunction

        function void match_fix(logic [DSQ_W-1:0] dsq, logic [DRES_W-1:0] dres,
                                logic signed [BEAR_W-1:0] bear, logic same);
            fix_t want;
            if (pending_fixes.size() == 0) begin
                $error("Result beat arrived with no pending point pair.");
                errors++;
                return;
            end
            want = pending_fixes.pop_front();
            fixes_checked++;
            if (dsq !== want.dist_squared) begin
                $error("dist_squared mismatch: expected %0d, actual %0d", want.dist_squared, dsq);
                errors++;
            end
            if (dres !== want.dist_res) begin
                $error("dist_res mismatch: expected %0d, actual %0d", want.dist_res, dres);
                errors++;
            end
            if (bear !== want.bearing) begin
                $error("bearing mismatch: expected %0d, actual %0d", want.bearing, bear);
                errors++;
            end
            if (same !== want.same_point) begin
                $error("same_point mismatch: expected %0d, actual %0d", want.same_point, same);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic idle_on;
    logic long_stall_req;
    int   stall_cycles;

    bearing_ledger ledger = new();

    pdb_in_if  pt_if ();
    pdb_out_if res_if ();

    point_distance_and_bearing_unit #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pt   (pt_if),
        .o_res  (res_if)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic send_pair(input int rx, input int ry, input int ox, input int oy);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 18);
            pt_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pt_if.valid   <= 1'b1;
        pt_if.ref_x   <= COORD_W'(rx);
        pt_if.ref_y   <= COORD_W'(ry);
        pt_if.other_x <= COORD_W'(ox);
        pt_if.other_y <= COORD_W'(oy);
        do @(posedge i_clk); while (!pt_if.ready);
    endtask

    function automatic pair_t random_pair();
        pair_t p;
        int    d;
        int    sel;
        int    corner[5];
        corner = '{-32768, -1, 0, 1, 32767};
        p.ref_x   = COORD_W'($urandom());
        p.ref_y   = COORD_W'($urandom());
        p.other_x = COORD_W'($urandom());
        p.other_y = COORD_W'($urandom());
        sel = $urandom_range(0, 9);
        case (sel)
            4: begin
                p.other_x = p.ref_x + COORD_W'($signed($urandom_range(0, 16)) - 8);
                p.other_y = p.ref_y + COORD_W'($signed($urandom_range(0, 16)) - 8);
            end
            5: p.other_x = p.ref_x;
            6: p.other_y = p.ref_y;
            7: begin
                p.other_x = p.ref_x;
                p.other_y = p.ref_y;
            end
            8: begin
                d = $urandom_range(1, 16383);
                p.ref_x   = COORD_W'($signed($urandom_range(0, 32767)) - 16384);
                p.ref_y   = COORD_W'($signed($urandom_range(0, 32767)) - 16384);
                p.other_x = p.ref_x + COORD_W'($urandom_range(0, 1) ? d : -d);
                p.other_y = p.ref_y + COORD_W'($urandom_range(0, 1) ? d : -d);
            end
            9: begin
                p.ref_x   = COORD_W'(corner[$urandom_range(0, 4)]);
                p.ref_y   = COORD_W'(corner[$urandom_range(0, 4)]);
                p.other_x = COORD_W'(corner[$urandom_range(0, 4)]);
                p.other_y = COORD_W'(corner[$urandom_range(0, 4)]);
            end
            default: ;
        endcase
        return p;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && pt_if.valid && pt_if.ready) begin
            ledger.note_pair(pt_if.ref_x, pt_if.ref_y, pt_if.other_x, pt_if.other_y);
        end
        if (i_rst_n && res_if.valid && res_if.ready) begin
            ledger.match_fix(res_if.dist_squared, res_if.dist_res, res_if.bearing,
                             res_if.same_point);
        end
    end

    initial begin
        int hold_left;
        hold_left = 0;
        stall_cycles = 0;
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                res_if.ready <= 1'b0;
                hold_left--;
            end else if (long_stall_req) begin
                long_stall_req = 1'b0;
                hold_left = LONG_STALL - 1;
                stall_cycles = LONG_STALL;
                res_if.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                hold_left = $urandom_range(1, 18) - 1;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        pair_t p;
        i_rst_n = 1'b0;
        idle_on = 1'b1;
        long_stall_req = 1'b0;
        pt_if.valid = 1'b0;
        pt_if.ref_x = '0;
        pt_if.ref_y = '0;
        pt_if.other_x = '0;
        pt_if.other_y = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_pair(0, 0, 0, 0);
        send_pair(-32768, -32768, -32768, -32768);
        send_pair(32767, 32767, 32767, 32767);
        send_pair(-32768, -32768, 32767, 32767);
        send_pair(32767, 32767, -32768, -32768);
        send_pair(-32768, 32767, 32767, -32768);
        send_pair(100, 100, 100, 200);
        send_pair(100, 100, 100, -32768);
        send_pair(0, 0, 0, 1);
        send_pair(-5, 7, 32767, 7);
        send_pair(-5, 7, -32768, 7);
        send_pair(0, 0, -1, 0);
        send_pair(0, 0, 1, 1);
        send_pair(0, 0, -1, 1);
        send_pair(0, 0, -1, -1);
        send_pair(0, 0, 1, -1);
        send_pair(-32768, -32768, -32767, 32767);
        send_pair(-32768, -32768, 32767, -32767);
        send_pair(32767, 32767, -32768, 32766);
        send_pair(-1, -1, 0, 0);
        send_pair(3, -4, 0, 0);

        for (int n = 0; n < RANDOM_PAIRS; n++) begin
            if (n % 100 == 0) begin
                idle_on = (n >= RANDOM_PAIRS - 150) ? 1'b0 : ($urandom_range(0, 3) != 0);
                if (n == 400) begin
                    idle_on = 1'b0;
                    long_stall_req = 1'b1;
                end
            end
            p = random_pair();
            send_pair(int'(p.ref_x), int'(p.ref_y), int'(p.other_x), int'(p.other_y));
        end
        pt_if.valid <= 1'b0;

        while (ledger.pending_fixes.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 10) @(posedge i_clk);

        $display("Sent %0d point pairs (extremes, axis, same-point and random quadrant cases).",
                 ledger.pairs_seen);
        $display("Checked %0d results, with one %0d-cycle output hold-off backing up the pipe.",
                 ledger.fixes_checked, stall_cycles);
        if (ledger.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
